// File: design/blms_pkg.sv
// ----------------------------------------------------------------------------
// blms_pkg
// shared types, tables and constants of the block-linear mip level size block
// ----------------------------------------------------------------------------
package blms_pkg;

  // fixed point of the tile-size reciprocal
  localparam int RecipK = 20;
  localparam int GobXLog2 = 6;
  localparam int GobYLog2 = 3;

  // level extent in format tiles, with the descriptor fields still needed
  typedef struct packed {
    logic [21:0] bx;
    logic [17:0] by;
    logic [11:0] bz;
    logic [2:0]  bws;
    logic [2:0]  bhs;
    logic [2:0]  bds;
    logic [2:0]  bpb;
    logic [2:0]  tws;
  } extent_t;

  // tile counts per axis and total shift
  typedef struct packed {
    logic [16:0] tx;
    logic [14:0] ty;
    logic [11:0] tz;
    logic [4:0]  shift;
  } tiles_t;

  // floor(2^RecipK / t) for tile sizes 1..15
  function automatic logic [20:0] recip(input logic [3:0] t);
    case (t)
      4'd2:    recip = 21'd524288;
      4'd3:    recip = 21'd349525;
      4'd4:    recip = 21'd262144;
      4'd5:    recip = 21'd209715;
      4'd6:    recip = 21'd174762;
      4'd7:    recip = 21'd149796;
      4'd8:    recip = 21'd131072;
      4'd9:    recip = 21'd116508;
      4'd10:   recip = 21'd104857;
      4'd11:   recip = 21'd95325;
      4'd12:   recip = 21'd87381;
      4'd13:   recip = 21'd80659;
      4'd14:   recip = 21'd74898;
      4'd15:   recip = 21'd69905;
      default: recip = 21'd1048576;
    endcase
  endfunction

endpackage

// File: design/blms_front.sv
// ----------------------------------------------------------------------------
// blms_front
// three stages: sample scaling and mip floor, reciprocal multiply, correction
// ----------------------------------------------------------------------------
module blms_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [14:0]          width,
  input  logic [14:0]          height,
  input  logic [11:0]          depth,
  input  logic [2:0]           block_width_shift,
  input  logic [2:0]           block_height_shift,
  input  logic [2:0]           block_depth_shift,
  input  logic [2:0]           bytes_per_block_log2,
  input  logic [3:0]           tile_width,
  input  logic [3:0]           tile_height,
  input  logic [2:0]           tile_width_spacing,
  input  logic [2:0]           sample_code,
  input  logic [3:0]           level,
  output logic                 ext_vld,
  output blms_pkg::extent_t    ext
);

  // stage a: operand fix-up, sample layout, mip floor
  logic [1:0]  ssx, ssy;
  logic [3:0]  tw, th;
  logic [2:0]  bpb;
  logic [16:0] ws, hs, fw, fh;
  logic [11:0] fd;

  always_comb begin
    case (sample_code)
      3'd1:    begin ssx = 2'd1; ssy = 2'd0; end
      3'd2:    begin ssx = 2'd1; ssy = 2'd1; end
      3'd3:    begin ssx = 2'd2; ssy = 2'd1; end
      3'd4:    begin ssx = 2'd2; ssy = 2'd2; end
      default: begin ssx = 2'd0; ssy = 2'd0; end
    endcase
    tw  = (tile_width == 4'd0) ? 4'd1 : tile_width;
    th  = (tile_height == 4'd0) ? 4'd1 : tile_height;
    bpb = (bytes_per_block_log2 > 3'd4) ? 3'd4 : bytes_per_block_log2;
    ws  = {2'b0, width} << ssx;
    hs  = {2'b0, height} << ssy;
    fw  = ws >> level;
    fh  = hs >> level;
    fd  = depth >> level;
    if (fw == 17'd0) fw = 17'd1;
    if (fh == 17'd0) fh = 17'd1;
    if (fd == 12'd0) fd = 12'd1;
  end

  logic        a_vld_r;
  logic [17:0] a_nw_r, a_nh_r;
  logic [3:0]  a_tw_r, a_th_r;
  logic [11:0] a_bz_r;
  logic [2:0]  a_bws_r, a_bhs_r, a_bds_r, a_bpb_r, a_tws_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_nw_r  <= {1'b0, fw} + {14'd0, tw} - 18'd1;
      a_nh_r  <= {1'b0, fh} + {14'd0, th} - 18'd1;
      a_tw_r  <= tw;
      a_th_r  <= th;
      a_bz_r  <= fd;
      a_bws_r <= block_width_shift;
      a_bhs_r <= block_height_shift;
      a_bds_r <= block_depth_shift;
      a_bpb_r <= bpb;
      a_tws_r <= tile_width_spacing;
    end
  end

  // stage b: quotient estimate by reciprocal, low by at most one
  logic [38:0] pw, ph;
  assign pw = {21'd0, a_nw_r} * {18'd0, blms_pkg::recip(a_tw_r)};
  assign ph = {21'd0, a_nh_r} * {18'd0, blms_pkg::recip(a_th_r)};

  logic        b_vld_r;
  logic [17:0] b_qw_r, b_qh_r, b_nw_r, b_nh_r;
  logic [3:0]  b_tw_r, b_th_r;
  logic [11:0] b_bz_r;
  logic [2:0]  b_bws_r, b_bhs_r, b_bds_r, b_bpb_r, b_tws_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_qw_r  <= pw[blms_pkg::RecipK +: 18];
      b_qh_r  <= ph[blms_pkg::RecipK +: 18];
      b_nw_r  <= a_nw_r;
      b_nh_r  <= a_nh_r;
      b_tw_r  <= a_tw_r;
      b_th_r  <= a_th_r;
      b_bz_r  <= a_bz_r;
      b_bws_r <= a_bws_r;
      b_bhs_r <= a_bhs_r;
      b_bds_r <= a_bds_r;
      b_bpb_r <= a_bpb_r;
      b_tws_r <= a_tws_r;
    end
  end

  // stage c: remainder check and byte scaling
  logic [21:0] rw, rh;
  logic [17:0] qw, qh;
  always_comb begin
    rw = {4'd0, b_nw_r} - ({4'd0, b_qw_r} * {18'd0, b_tw_r});
    rh = {4'd0, b_nh_r} - ({4'd0, b_qh_r} * {18'd0, b_th_r});
    qw = (rw >= {18'd0, b_tw_r}) ? b_qw_r + 18'd1 : b_qw_r;
    qh = (rh >= {18'd0, b_th_r}) ? b_qh_r + 18'd1 : b_qh_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_vld <= 1'b0;
    end else if (en) begin
      ext_vld <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ext.bx  <= {4'd0, qw} << b_bpb_r;
      ext.by  <= qh;
      ext.bz  <= b_bz_r;
      ext.bws <= b_bws_r;
      ext.bhs <= b_bhs_r;
      ext.bds <= b_bds_r;
      ext.bpb <= b_bpb_r;
      ext.tws <= b_tws_r;
    end
  end

endmodule

// File: design/blms_tiles.sv
// ----------------------------------------------------------------------------
// blms_tiles
// one stage: block shift shrink, gob counts, width alignment, tile counts
// ----------------------------------------------------------------------------
module blms_tiles (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 ext_vld,
  input  blms_pkg::extent_t    ext,
  output logic                 til_vld,
  output blms_pkg::tiles_t     til
);

  // largest s up to shift with s zero or (unit << (s-1)) < dim
  function automatic logic [2:0] shrink(input logic [2:0] shift,
                                        input logic [22:0] unit,
                                        input logic [22:0] dim);
    logic [2:0] r;
    r = 3'd0;
    for (int s = 1; s < 8; s++) begin
      if (3'(s) <= shift && (unit << (s - 1)) < dim) r = 3'(s);
    end
    return r;
  endfunction

  logic [2:0]  sx, sy, sz, al;
  logic [3:0]  ex;
  logic [16:0] gx, gy, gxa;
  logic        sml;
  logic [17:0] tx, ty;
  logic [12:0] tz;

  always_comb begin
    sx  = shrink(ext.bws, 23'd64, {1'b0, ext.bx});
    sy  = shrink(ext.bhs, 23'd8, {5'd0, ext.by});
    sz  = shrink(ext.bds, 23'd1, {11'd0, ext.bz});
    gx  = 17'(({1'b0, ext.bx} + 23'd63) >> blms_pkg::GobXLog2);
    gy  = 17'(({1'b0, ext.by} + 19'd7) >> blms_pkg::GobYLog2);
    ex  = 4'd6 - {1'b0, ext.bpb} + {1'b0, ext.tws};
    sml = (ext.bx <= (22'd1 << ex)) ||
          (ext.by <= (18'd1 << (4'd3 + {1'b0, ext.bhs}))) ||
          (ext.bz < (12'd1 << ext.bds));
    al  = sml ? 3'd0 : ext.tws;
    gxa = 17'(((({1'b0, gx} + ((18'd1 << al) - 18'd1)) >> al)) << al);
    tx  = ({1'b0, gxa} + ((18'd1 << sx) - 18'd1)) >> sx;
    ty  = ({1'b0, gy} + ((18'd1 << sy) - 18'd1)) >> sy;
    tz  = ({1'b0, ext.bz} + ((13'd1 << sz) - 13'd1)) >> sz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      til_vld <= 1'b0;
    end else if (en) begin
      til_vld <= ext_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      til.tx    <= tx[16:0];
      til.ty    <= ty[14:0];
      til.tz    <= tz[11:0];
      til.shift <= 5'(blms_pkg::GobXLog2 + blms_pkg::GobYLog2)
                   + {2'd0, sx} + {2'd0, sy} + {2'd0, sz};
    end
  end

endmodule

// File: design/blms_mul.sv
// ----------------------------------------------------------------------------
// blms_mul
// three stages: x by y product, times z, final byte shift
// ----------------------------------------------------------------------------
module blms_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 til_vld,
  input  blms_pkg::tiles_t     til,
  output logic                 res_vld,
  output logic [31:0]          res
);

  logic        e_vld_r, f_vld_r;
  logic [31:0] e_p_r, f_p_r;
  logic [11:0] e_tz_r;
  logic [4:0]  e_sh_r, f_sh_r;
  logic [43:0] pz;

  assign pz = {12'd0, e_p_r} * {32'd0, e_tz_r};

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
      res_vld <= 1'b0;
    end else if (en) begin
      e_vld_r <= til_vld;
      f_vld_r <= e_vld_r;
      res_vld <= f_vld_r;
    end
  end

  // products, kept modulo 2^32
  always_ff @(posedge clk) begin
    if (en) begin
      e_p_r  <= {15'd0, til.tx} * {17'd0, til.ty};
      e_tz_r <= til.tz;
      e_sh_r <= til.shift;
      f_p_r  <= pz[31:0];
      f_sh_r <= e_sh_r;
      res    <= f_p_r << f_sh_r;
    end
  end

endmodule

// File: design/block_linear_mip_level_size.sv
// ----------------------------------------------------------------------------
// block_linear_mip_level_size
// byte size of one mip level of a gob-tiled surface
// ----------------------------------------------------------------------------
// Seven-stage pipeline: a descriptor word is taken every cycle while the
// output is not stalled; the tile division by reciprocal multiply and the
// two 32-bit product stages set the depth. A stall on the output freezes
// the whole pipeline, and in_ready follows out_ready then.
module block_linear_mip_level_size (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [14:0] in_width,
  input  logic [14:0] in_height,
  input  logic [11:0] in_depth,
  input  logic [2:0]  in_block_width_shift,
  input  logic [2:0]  in_block_height_shift,
  input  logic [2:0]  in_block_depth_shift,
  input  logic [2:0]  in_bytes_per_block_log2,
  input  logic [3:0]  in_tile_width,
  input  logic [3:0]  in_tile_height,
  input  logic [2:0]  in_tile_width_spacing,
  input  logic [2:0]  in_sample_code,
  input  logic [3:0]  in_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_level_size
);

  logic              en;
  logic              ext_vld, til_vld;
  blms_pkg::extent_t ext;
  blms_pkg::tiles_t  til;

  // pipeline advances unless a finished word is held
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  blms_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .en                   (en),
    .in_vld               (in_valid),
    .width                (in_width),
    .height               (in_height),
    .depth                (in_depth),
    .block_width_shift    (in_block_width_shift),
    .block_height_shift   (in_block_height_shift),
    .block_depth_shift    (in_block_depth_shift),
    .bytes_per_block_log2 (in_bytes_per_block_log2),
    .tile_width           (in_tile_width),
    .tile_height          (in_tile_height),
    .tile_width_spacing   (in_tile_width_spacing),
    .sample_code          (in_sample_code),
    .level                (in_level),
    .ext_vld              (ext_vld),
    .ext                  (ext)
  );

  blms_tiles u_tiles (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ext_vld (ext_vld),
    .ext     (ext),
    .til_vld (til_vld),
    .til     (til)
  );

  blms_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .til_vld (til_vld),
    .til     (til),
    .res_vld (out_valid),
    .res     (out_level_size)
  );

  // a size always carries at least the 512-byte gob shift
  a_gob_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_level_size[8:0] == 9'd0))
    else $error("level size not gob aligned");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a held word freezes the tile stage
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(til_vld) && $stable(til))
    else $error("pipeline moved during stall");

endmodule
